FILE: src/hsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_pkg
// shared types and constants of the hinted slot allocator
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int REQ_W     = 3;
    localparam int ITEM_W    = 16;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd52;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD         = 3'd0,
        REQ_REMOVE_SLOT = 3'd1,
        REQ_REMOVE_ITEM = 3'd2,
        REQ_MOVE_SLOT   = 3'd3,
        REQ_MOVE_ITEM   = 3'd4,
        REQ_LOOKUP_SLOT = 3'd5,
        REQ_FIND_ITEM   = 3'd6
    } t_req_type;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_BAD_TARGET = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // write command broadcast to every cell
    typedef struct packed {
        logic wr_src;
        logic src_used;
        logic wr_dst;
    } t_cell_cmd;

    // search flags travelling along the cell chain
    typedef struct packed {
        logic free_hit;
        logic match_hit;
    } t_cell_hit;

endpackage
`default_nettype wire

FILE: src/hsa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_req_if
// request channel: valid/ready handshake with the request payload
// ----------------------------------------------------------------------------
interface hsa_req_if;
    logic                           valid;
    logic                           ready;
    logic [hsa_pkg::REQ_W-1:0]      req_type;
    logic [hsa_pkg::ITEM_W-1:0]     item_id;
    logic [hsa_pkg::SLOT_W-1:0]     slot;
    logic [hsa_pkg::SLOT_W-1:0]     new_slot;

    modport source (output valid, req_type, item_id, slot, new_slot, input ready);
    modport sink   (input valid, req_type, item_id, slot, new_slot, output ready);
endinterface
`default_nettype wire

FILE: src/hsa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_rsp_if
// result channel: valid/ready handshake with the result payload
// ----------------------------------------------------------------------------
interface hsa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [hsa_pkg::STATUS_W-1:0]   status;
    logic [hsa_pkg::SLOT_W-1:0]     result_slot;
    logic [hsa_pkg::ITEM_W-1:0]     result_item;

    modport source (output valid, status, result_slot, result_item, input ready);
    modport sink   (input valid, status, result_slot, result_item, output ready);
endinterface
`default_nettype wire

FILE: src/hsa_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_cfg_if
// configuration write channel for the slots_in_use register
// ----------------------------------------------------------------------------
interface hsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hsa_pkg::CFG_W-1:0]      slots_in_use;

    modport source (output valid, slots_in_use, input ready);
    modport sink   (input valid, slots_in_use, output ready);
endinterface
`default_nettype wire

FILE: src/hsa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_cell
// one slot of the table: occupancy bit, item word and its link in the chain
// ----------------------------------------------------------------------------
module hsa_cell #(
    parameter int IDX = 0,
    parameter int IW  = 16,
    parameter int AW  = 6,
    parameter int NW  = 7
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  [NW-1:0]           i_n,
    input  wire  [IW-1:0]           i_key,
    input  wire hsa_pkg::t_cell_hit i_below,
    output hsa_pkg::t_cell_hit      o_below,
    output hsa_pkg::t_cell_hit      o_first,
    input  wire hsa_pkg::t_cell_cmd i_cmd,
    input  wire  [AW-1:0]           i_src_idx,
    input  wire  [AW-1:0]           i_dst_idx,
    input  wire  [IW-1:0]           i_src_item,
    input  wire  [IW-1:0]           i_dst_item,
    output logic                    o_used,
    output logic [IW-1:0]           o_item
);

    logic               r_used;
    logic [IW-1:0]      r_item;
    logic               slot_valid;
    logic               is_src;
    logic               is_dst;
    hsa_pkg::t_cell_hit hit;

    assign slot_valid    = NW'(IDX) < i_n;
    assign hit.free_hit  = slot_valid && !r_used;
    assign hit.match_hit = slot_valid && r_used && (r_item == i_key);

    // lowest hit wins: a hit counts only if nothing below has one
    assign o_first.free_hit  = hit.free_hit  && !i_below.free_hit;
    assign o_first.match_hit = hit.match_hit && !i_below.match_hit;
    assign o_below.free_hit  = hit.free_hit  || i_below.free_hit;
    assign o_below.match_hit = hit.match_hit || i_below.match_hit;

    assign is_src = i_cmd.wr_src && (i_src_idx == AW'(IDX));
    assign is_dst = i_cmd.wr_dst && (i_dst_idx == AW'(IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (is_dst) begin
            r_used <= 1'b1;
        end else if (is_src) begin
            r_used <= i_cmd.src_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_dst) begin
            r_item <= i_dst_item;
        end else if (is_src) begin
            r_item <= i_src_item;
        end
    end

    assign o_used = r_used;
    assign o_item = r_item;

endmodule
`default_nettype wire

FILE: src/hinted_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hinted_slot_allocator
// slot table binding item identifiers to priority-ordered slots
// ----------------------------------------------------------------------------
// The table is a row of SLOTS cells, one per slot, each holding an occupancy
// bit and an item word. An accepted request passes a scan state, in which
// every cell compares itself against the request and the lowest free slot
// and the lowest matching slot ripple out along the chain, and an execute
// state, in which the operation is decided and the (at most two) cell
// writes of add, remove or swapping move land together. The next request
// may be accepted in the execute state while the current one retires, once
// the output register is free. The result is registered from the execute
// state, which waits while a previous result is still held in the output
// register. Occupancy is cleared at reset; item words are only read from
// occupied slots and are not reset. slots_in_use (reset 52) limits the
// visible slots to min(slots_in_use, SLOTS) and is to be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module hinted_slot_allocator #(
    parameter int SLOTS        = 64,
    parameter int ITEM_ID_BITS = 16
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    hsa_req_if.sink   i_req,
    hsa_rsp_if.source o_rsp,
    hsa_cfg_if.sink   i_cfg
);

    localparam int IW  = ITEM_ID_BITS;
    localparam int AW  = ($clog2(SLOTS) > hsa_pkg::SLOT_W) ? $clog2(SLOTS) : hsa_pkg::SLOT_W;
    localparam int NW  = ($clog2(SLOTS + 1) > hsa_pkg::CFG_W) ?
                         $clog2(SLOTS + 1) : hsa_pkg::CFG_W;

    // state and request registers
    hsa_pkg::t_state                    r_state, n_state;
    logic [hsa_pkg::CFG_W-1:0]          r_cfg;
    logic [hsa_pkg::REQ_W-1:0]          r_req_type;
    logic [hsa_pkg::ITEM_W-1:0]         r_item;
    logic [hsa_pkg::SLOT_W-1:0]         r_slot;
    logic [hsa_pkg::SLOT_W-1:0]         r_new_slot;

    // scan results
    logic                               r_free_ok;
    logic [AW-1:0]                      r_free_idx;
    logic                               r_match_ok;
    logic [AW-1:0]                      r_match_idx;

    // output register
    logic                               r_out_valid;
    logic [hsa_pkg::STATUS_W-1:0]       r_status;
    logic [hsa_pkg::SLOT_W-1:0]         r_rslot;
    logic [hsa_pkg::ITEM_W-1:0]         r_ritem;

    logic                               in_ready;
    logic                               in_accept;
    logic                               out_free;
    logic                               commit;

    // effective slot count and search key
    logic [NW-1:0]                      n_lim;
    logic [NW-1:0]                      cfg_ext;
    logic [IW+hsa_pkg::ITEM_W-1:0]      key_ext;
    logic [IW-1:0]                      key;

    // cell chain
    hsa_pkg::t_cell_hit                 chain [SLOTS+1];
    hsa_pkg::t_cell_hit                 first [SLOTS];
    logic                               cell_used [SLOTS];
    logic [IW-1:0]                      cell_item [SLOTS];
    hsa_pkg::t_cell_cmd                 cmd;
    logic [AW-1:0]                      wr_src_idx;
    logic [AW-1:0]                      wr_dst_idx;
    logic [IW-1:0]                      wr_src_item;
    logic [IW-1:0]                      wr_dst_item;

    // scan encoding
    logic [AW-1:0]                      free_idx_c;
    logic [AW-1:0]                      match_idx_c;

    // execute decode
    logic                               item_op;
    logic [AW-1:0]                      s_ext;
    logic [AW-1:0]                      ns_ext;
    logic                               s_ok;
    logic                               dst_ok;
    logic                               src_ok;
    logic [AW-1:0]                      src_idx;
    logic                               used_src;
    logic                               used_dst;
    logic [IW-1:0]                      word_src;
    logic [IW-1:0]                      word_dst;
    logic [hsa_pkg::STATUS_W-1:0]       ex_status;
    logic [AW-1:0]                      ex_slot;
    logic [IW-1:0]                      ex_item;
    logic [IW+hsa_pkg::ITEM_W-1:0]      ex_item_ext;

    // configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hsa_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_cfg <= i_cfg.slots_in_use;
        end
    end

    assign cfg_ext = NW'(r_cfg);
    assign n_lim   = (cfg_ext < NW'(SLOTS)) ? cfg_ext : NW'(SLOTS);

    // key narrowed or zero-extended to the stored item width
    assign key_ext = {{IW{1'b0}}, r_item};
    assign key     = key_ext[IW-1:0];

    // handshake
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign commit    = (r_state == hsa_pkg::S_EXEC) && out_free;
    assign in_accept = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        unique case (r_state)
            hsa_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = hsa_pkg::S_SCAN;
                end
            end
            hsa_pkg::S_SCAN: begin
                n_state = hsa_pkg::S_EXEC;
            end
            hsa_pkg::S_EXEC: begin
                // next request may enter while this one retires
                in_ready = out_free;
                if (out_free) begin
                    n_state = i_req.valid ? hsa_pkg::S_SCAN : hsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsa_pkg::S_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_req.req_type;
            r_item     <= i_req.item_id;
            r_slot     <= i_req.slot;
            r_new_slot <= i_req.new_slot;
        end
    end

    // row of cells, lowest slot at the head of the chain
    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        hsa_cell #(
            .IDX (g),
            .IW  (IW),
            .AW  (AW),
            .NW  (NW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_n        (n_lim),
            .i_key      (key),
            .i_below    (chain[g]),
            .o_below    (chain[g+1]),
            .o_first    (first[g]),
            .i_cmd      (cmd),
            .i_src_idx  (wr_src_idx),
            .i_dst_idx  (wr_dst_idx),
            .i_src_item (wr_src_item),
            .i_dst_item (wr_dst_item),
            .o_used     (cell_used[g]),
            .o_item     (cell_item[g])
        );
    end

    // one-hot first hits to slot numbers
    always_comb begin
        free_idx_c  = '0;
        match_idx_c = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (first[i].free_hit) begin
                free_idx_c = free_idx_c | AW'(i);
            end
            if (first[i].match_hit) begin
                match_idx_c = match_idx_c | AW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hsa_pkg::S_SCAN) begin
            r_free_ok   <= chain[SLOTS].free_hit;
            r_free_idx  <= free_idx_c;
            r_match_ok  <= chain[SLOTS].match_hit;
            r_match_idx <= match_idx_c;
        end
    end

    // execute: source is the given slot or the found slot
    assign item_op = (r_req_type == hsa_pkg::REQ_REMOVE_ITEM) ||
                     (r_req_type == hsa_pkg::REQ_MOVE_ITEM);
    assign s_ext   = AW'(r_slot);
    assign ns_ext  = AW'(r_new_slot);
    assign s_ok    = NW'(r_slot) < n_lim;
    assign dst_ok  = NW'(r_new_slot) < n_lim;
    assign src_idx = item_op ? r_match_idx : s_ext;
    assign src_ok  = item_op ? r_match_ok : s_ok;

    // gather source and target words from the row
    always_comb begin
        used_src = 1'b0;
        used_dst = 1'b0;
        word_src = '0;
        word_dst = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (src_idx == AW'(i)) begin
                used_src = used_src | cell_used[i];
                word_src = word_src | cell_item[i];
            end
            if (ns_ext == AW'(i)) begin
                used_dst = used_dst | cell_used[i];
                word_dst = word_dst | cell_item[i];
            end
        end
    end

    always_comb begin
        cmd         = '0;
        wr_src_idx  = src_idx;
        wr_dst_idx  = ns_ext;
        wr_src_item = word_dst;
        wr_dst_item = word_src;
        ex_status   = hsa_pkg::STAT_NOT_FOUND;
        ex_slot     = '0;
        ex_item     = '0;
        unique case (r_req_type)
            hsa_pkg::REQ_ADD: begin
                if (s_ok && !used_src) begin
                    // hint is valid and free
                    ex_status   = hsa_pkg::STAT_OK;
                    ex_slot     = s_ext;
                    cmd.wr_dst  = 1'b1;
                    wr_dst_idx  = s_ext;
                    wr_dst_item = key;
                end else if (r_free_ok) begin
                    ex_status   = hsa_pkg::STAT_OK;
                    ex_slot     = r_free_idx;
                    cmd.wr_dst  = 1'b1;
                    wr_dst_idx  = r_free_idx;
                    wr_dst_item = key;
                end else begin
                    ex_status   = hsa_pkg::STAT_FULL;
                end
            end
            hsa_pkg::REQ_REMOVE_SLOT, hsa_pkg::REQ_REMOVE_ITEM: begin
                if (src_ok && used_src) begin
                    ex_status    = hsa_pkg::STAT_OK;
                    ex_slot      = src_idx;
                    ex_item      = word_src;
                    cmd.wr_src   = 1'b1;
                    cmd.src_used = 1'b0;
                end
            end
            hsa_pkg::REQ_MOVE_SLOT, hsa_pkg::REQ_MOVE_ITEM: begin
                if (!(src_ok && used_src)) begin
                    ex_status = hsa_pkg::STAT_NOT_FOUND;
                end else if (!dst_ok) begin
                    ex_status = hsa_pkg::STAT_BAD_TARGET;
                end else begin
                    // occupied target swaps back into the source
                    ex_status    = hsa_pkg::STAT_OK;
                    ex_slot      = ns_ext;
                    ex_item      = word_src;
                    cmd.wr_src   = 1'b1;
                    cmd.src_used = used_dst;
                    wr_src_item  = word_dst;
                    cmd.wr_dst   = 1'b1;
                    wr_dst_idx   = ns_ext;
                    wr_dst_item  = word_src;
                end
            end
            hsa_pkg::REQ_LOOKUP_SLOT: begin
                if (s_ok && used_src) begin
                    ex_status = hsa_pkg::STAT_OK;
                    ex_slot   = s_ext;
                    ex_item   = word_src;
                end
            end
            hsa_pkg::REQ_FIND_ITEM: begin
                if (r_match_ok) begin
                    ex_status = hsa_pkg::STAT_OK;
                    ex_slot   = r_match_idx;
                    ex_item   = key;
                end
            end
            default: begin
                ex_status = hsa_pkg::STAT_NOT_FOUND;
            end
        endcase
        // writes land only when the result can be stored
        cmd.wr_src = cmd.wr_src && commit;
        cmd.wr_dst = cmd.wr_dst && commit;
    end

    assign ex_item_ext = {{hsa_pkg::ITEM_W{1'b0}}, ex_item};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_status <= ex_status;
            r_rslot  <= ex_slot[hsa_pkg::SLOT_W-1:0];
            r_ritem  <= ex_item_ext[hsa_pkg::ITEM_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.result_slot = r_rslot;
    assign o_rsp.result_item = r_ritem;

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hinted slot allocator: a shadow copy of the
// slot table predicts every result, which is checked field by field in order
// ----------------------------------------------------------------------------
module tb;
    import hsa_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int NUM_SLOTS     = 1 << SLOT_W;
    localparam int LONG_HOLD     = 60;
    localparam int END_SETTLE    = 8;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SHOW_LIMIT    = 40;
    localparam int NUM_PHASES    = 8;
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 3'd7;

    // register setting and length of each random phase
    localparam int PHASE_CFG [NUM_PHASES] = '{64, 1, 52, 127, 6, 0, 33, 64};
    localparam int PHASE_LEN [NUM_PHASES] = '{220, 100, 220, 180, 120, 20, 180, 210};

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ITEM_W-1:0] item;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] new_slot;
    } slot_request_t;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [ITEM_W-1:0] item;
    } answer_t;

    // ------------------------------------------------------------------------
    // shadow slot table: occupancy, item words, the register, and the
    // answers still owed by the block
    // ------------------------------------------------------------------------
    class slot_table_shadow;
        bit                slot_taken [NUM_SLOTS];
        logic [ITEM_W-1:0] slot_word  [NUM_SLOTS];
        logic [CFG_W-1:0]  slots_in_use;
        answer_t           answers_due [$];
        int                errors;

        function new();
            slots_in_use = CFG_RESET;
            errors = 0;
            foreach (slot_taken[i]) begin
                slot_taken[i] = 1'b0;
                slot_word[i] = '0;
            end
        endfunction

        function int visible();
            return (int'(slots_in_use) < NUM_SLOTS) ? int'(slots_in_use) : NUM_SLOTS;
        endfunction

        function int occupancy();
            int cnt;
            cnt = 0;
            for (int i = 0; i < visible(); i++)
                if (slot_taken[i]) cnt++;
            return cnt;
        endfunction

        function int pending_count();
            return answers_due.size();
        endfunction

        // lowest visible occupied slot holding this item, -1 if none
        function int lowest_match(logic [ITEM_W-1:0] id, int n);
            for (int i = 0; i < n; i++)
                if (slot_taken[i] && slot_word[i] == id) return i;
            return -1;
        endfunction

        function void push_answer(t_status st, int s, logic [ITEM_W-1:0] id);
            answer_t a;
            a.status = st;
            a.slot   = (st == STAT_OK) ? s[SLOT_W-1:0] : '0;
            a.item   = (st == STAT_OK) ? id : '0;
            answers_due.push_back(a);
        endfunction

        // missing source wins over a bad target; occupied target swaps
        function void move_entry(int src, int dst, int n);
            logic [ITEM_W-1:0] moved;
            if (src < 0 || src >= n || !slot_taken[src]) begin
                push_answer(STAT_NOT_FOUND, 0, '0);
            end else if (dst >= n) begin
                push_answer(STAT_BAD_TARGET, 0, '0);
            end else begin
                moved = slot_word[src];
                slot_taken[src] = 1'b0;
                if (slot_taken[dst]) begin
                    slot_word[src] = slot_word[dst];
                    slot_taken[src] = 1'b1;
                end
                slot_word[dst] = moved;
                slot_taken[dst] = 1'b1;
                push_answer(STAT_OK, dst, moved);
            end
        endfunction

        function void note_request(slot_request_t r);
            int n;
            int f;
            n = visible();
            f = -1;
            case (r.kind)
                REQ_ADD: begin
                    if (int'(r.slot) < n && !slot_taken[r.slot]) begin
                        f = int'(r.slot);
                    end else begin
                        for (int i = 0; i < n; i++)
                            if (f < 0 && !slot_taken[i]) f = i;
                    end
                    if (f < 0) begin
                        push_answer(STAT_FULL, 0, '0);
                    end else begin
                        slot_taken[f] = 1'b1;
                        slot_word[f] = r.item;
                        push_answer(STAT_OK, f, '0);
                    end
                end
                REQ_REMOVE_SLOT, REQ_REMOVE_ITEM: begin
                    f = (r.kind == REQ_REMOVE_SLOT) ? int'(r.slot) : lowest_match(r.item, n);
                    if (f < 0 || f >= n || !slot_taken[f]) begin
                        push_answer(STAT_NOT_FOUND, 0, '0);
                    end else begin
                        slot_taken[f] = 1'b0;
                        push_answer(STAT_OK, f, slot_word[f]);
                    end
                end
                REQ_MOVE_SLOT: move_entry(int'(r.slot), int'(r.new_slot), n);
                REQ_MOVE_ITEM: move_entry(lowest_match(r.item, n), int'(r.new_slot), n);
                REQ_LOOKUP_SLOT: begin
                    if (int'(r.slot) < n && slot_taken[r.slot])
                        push_answer(STAT_OK, int'(r.slot), slot_word[r.slot]);
                    else
                        push_answer(STAT_NOT_FOUND, 0, '0);
                end
                REQ_FIND_ITEM: begin
                    f = lowest_match(r.item, n);
                    if (f < 0) push_answer(STAT_NOT_FOUND, 0, '0);
                    else push_answer(STAT_OK, f, r.item);
                end
                default: push_answer(STAT_NOT_FOUND, 0, '0);
            endcase
        endfunction

        task report_mismatch(string what);
            if (errors < SHOW_LIMIT) $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_answer(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s,
                          logic [ITEM_W-1:0] id);
            answer_t a;
            if (answers_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            a = answers_due.pop_front();
            if (st !== a.status)
                report_mismatch($sformatf("status %0d, want %0d", st, a.status));
            if (s !== a.slot)
                report_mismatch($sformatf("result_slot %0d, want %0d", s, a.slot));
            if (id !== a.item)
                report_mismatch($sformatf("result_item %h, want %h", id, a.item));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    hsa_req_if req_ch ();
    hsa_rsp_if rsp_ch ();
    hsa_cfg_if cfg_ch ();

    hinted_slot_allocator uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    slot_table_shadow sb = new();

    bit   allow_idle  = 1'b1;   // random stalls on both sides
    bit   hold_active = 1'b0;   // long result hold-off in progress
    event start_long_hold;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // generous upper bound on the whole run
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end

    // long hold-off, counted here so the sender keeps going meanwhile
    initial begin
        forever begin
            @(start_long_hold);
            hold_active <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // result side: check each transaction, then pick ready for the next cycle
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_answer(rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_item);
            if (!rst_n || hold_active) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                // start a random burst of stalls, this one included
                stall_left = $urandom_range(1, 7) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // valid is left high so back-to-back transactions never toggle it
    task automatic send_request(input slot_request_t r);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.item_id  <= r.item;
        req_ch.slot     <= r.slot;
        req_ch.new_slot <= r.new_slot;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        sb.note_request(r);
    endtask

    task automatic issue(input logic [REQ_W-1:0] kind, input logic [ITEM_W-1:0] id,
                         input logic [SLOT_W-1:0] s, input logic [SLOT_W-1:0] ns);
        slot_request_t r;
        r.kind     = kind;
        r.item     = id;
        r.slot     = s;
        r.new_slot = ns;
        send_request(r);
    endtask

    task automatic req_gap(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
    endtask

    // register writes only with the block idle
    task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.slots_in_use <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.slots_in_use = value;
    endtask

    // mostly items already in the table, so searches and removes hit
    function automatic logic [ITEM_W-1:0] choose_item(input bit fresh);
        int held [$];
        if (!fresh) begin
            for (int i = 0; i < sb.visible(); i++)
                if (sb.slot_taken[i]) held.push_back(i);
            if (held.size() > 0 && $urandom_range(0, 9) < 7)
                return sb.slot_word[held[$urandom_range(0, held.size() - 1)]];
        end
        case ($urandom_range(0, 3))
            0: return ITEM_W'($urandom_range(0, 15));   // small pool, duplicates
            1: return $urandom_range(0, 1) ? {ITEM_W{1'b1}} : {ITEM_W{1'b0}};
            default: return ITEM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic slot_request_t random_request();
        slot_request_t r;
        int n;
        int top;
        int add_share;
        n = sb.visible();
        top = (n > 0) ? n - 1 : 0;
        // fewer adds once the table is half full, so it keeps turning over
        add_share = (2 * sb.occupancy() < n) ? 40 : 15;
        if ($urandom_range(0, 99) < 2) begin
            r.kind = REQ_UNDEFINED;
        end else if ($urandom_range(0, 99) < add_share) begin
            r.kind = REQ_ADD;
        end else begin
            case ($urandom_range(0, 5))
                0: r.kind = REQ_REMOVE_SLOT;
                1: r.kind = REQ_REMOVE_ITEM;
                2: r.kind = REQ_MOVE_SLOT;
                3: r.kind = REQ_MOVE_ITEM;
                4: r.kind = REQ_LOOKUP_SLOT;
                default: r.kind = REQ_FIND_ITEM;
            endcase
        end
        r.item = choose_item(r.kind == REQ_ADD);
        // mostly visible slots, now and then anywhere in the field
        r.slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, NUM_SLOTS - 1))
                                             : SLOT_W'($urandom_range(0, top));
        r.new_slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, NUM_SLOTS - 1))
                                                 : SLOT_W'($urandom_range(0, top));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_ADD;
        req_ch.item_id      <= '0;
        req_ch.slot         <= '0;
        req_ch.new_slot     <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.slots_in_use <= CFG_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register still at its reset value
        issue(REQ_LOOKUP_SLOT, 16'h0000, 6'd0,  6'd0);   // empty table
        issue(REQ_FIND_ITEM,   16'h0000, 6'd0,  6'd0);
        issue(REQ_ADD,         16'hFFFF, 6'd63, 6'd0);   // hint beyond the visible slots
        issue(REQ_ADD,         16'h0000, 6'd5,  6'd0);   // hint honoured
        issue(REQ_ADD,         16'hFFFF, 6'd5,  6'd0);   // hint taken, duplicate item
        issue(REQ_FIND_ITEM,   16'hFFFF, 6'd0,  6'd0);   // lowest of two matches
        issue(REQ_MOVE_SLOT,   16'h0000, 6'd0,  6'd63);  // bad target
        issue(REQ_MOVE_SLOT,   16'h0000, 6'd2,  6'd63);  // empty source beats bad target
        issue(REQ_MOVE_SLOT,   16'h0000, 6'd5,  6'd5);   // onto itself
        issue(REQ_MOVE_SLOT,   16'h0000, 6'd5,  6'd0);   // swap with occupied target
        issue(REQ_MOVE_ITEM,   16'hFFFF, 6'd0,  6'd10);
        issue(REQ_REMOVE_ITEM, 16'h0000, 6'd0,  6'd0);
        issue(REQ_REMOVE_SLOT, 16'h0000, 6'd5,  6'd0);
        issue(REQ_REMOVE_SLOT, 16'h0000, 6'd63, 6'd0);   // invisible slot
        issue(REQ_UNDEFINED,   16'hFFFF, 6'd63, 6'd63);
        issue(REQ_LOOKUP_SLOT, 16'h0000, 6'd10, 6'd0);

        // shrink to two slots: fill them, then full table
        write_slots_in_use(7'd2);
        issue(REQ_ADD, 16'h5555, 6'd1, 6'd0);
        issue(REQ_ADD, 16'hAAAA, 6'd1, 6'd0);
        issue(REQ_ADD, 16'h1234, 6'd0, 6'd0);

        // no visible slot at all
        write_slots_in_use(7'd0);
        issue(REQ_ADD,         16'h1234, 6'd0, 6'd0);
        issue(REQ_LOOKUP_SLOT, 16'h0000, 6'd0, 6'd0);

        // register above the table size, hidden contents come back
        write_slots_in_use(7'd127);
        issue(REQ_LOOKUP_SLOT, 16'h0000, 6'd63, 6'd0);
        issue(REQ_ADD,         16'h8001, 6'd63, 6'd0);
        issue(REQ_LOOKUP_SLOT, 16'h0000, 6'd10, 6'd0);

        // random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slots_in_use(CFG_W'(PHASE_CFG[p]));
            // last phase runs flat out on both sides
            if (p == NUM_PHASES - 1) allow_idle = 1'b0;
            // results held off for a long stretch: the block backs up
            if (p == 0) -> start_long_hold;
            for (int k = 0; k < PHASE_LEN[p]; k++) begin
                // sender pauses once mid-phase until nothing is owed
                if (p == 3 && k == 90) drain_results();
                if (allow_idle && $urandom_range(0, 5) == 0)
                    req_gap($urandom_range(1, 7));
                send_request(random_request());
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
